[hw/rtl/hbpt_pkg.sv]
// Shared types, constants and helpers of the histogram beam prune threshold unit.
`timescale 1ns / 1ps
`default_nettype none
package hbpt_pkg;

    // Field widths.
    localparam int REQ_W      = 2;
    localparam int SCORE_W    = 32;
    localparam int CNT_W      = 24;
    localparam int BW_W       = 31;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 66;

    // Default histogram depth.
    localparam int NUM_BINS_DEF = 1024;

    // Score limits and the saturated bin count.
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic [CNT_W-1:0]          CNT_MAX   = 24'hFF_FFFF;

    // Register reset values.
    localparam logic signed [SCORE_W-1:0] FLOOR_RST   = -32'sd1024000;
    localparam logic signed [SCORE_W-1:0] CEILING_RST = 32'sd0;
    localparam logic [BW_W-1:0]           BIN_W_RST   = 31'd1024;
    localparam logic [SCALE_W-1:0]        SCALE_RST   = 32'd65536;
    localparam logic [CNT_W-1:0]          LIMIT_RST   = 24'd1000;
    localparam logic [BW_W-1:0]           BEAM_RST    = 31'd0;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_FLOOR   = 3'd0,
        CFG_SCORE_CEILING = 3'd1,
        CFG_BIN_WIDTH     = 3'd2,
        CFG_BIN_SCALE     = 3'd3,
        CFG_COUNT_LIMIT   = 3'd4,
        CFG_BEAM_WIDTH    = 3'd5
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADD_BIN,
        ST_ADD_RD,
        ST_Q_SMIN,
        ST_Q_EMAX,
        ST_Q_WALK,
        ST_Q_THR,
        ST_RESP
    } t_state;

    // Operations of the shared multiply unit.
    typedef enum logic {
        MUL_BIN,
        MUL_THR
    } t_mul_op;

    // Configuration register set.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score_floor;
        logic signed [SCORE_W-1:0] score_ceiling;
        logic [BW_W-1:0]           bin_step;
        logic [SCALE_W-1:0]        bin_scale;
        logic [CNT_W-1:0]          count_limit;
        logic [BW_W-1:0]           beam_width;
    } t_cfg;

    // Command to the shared multiply unit.
    typedef struct packed {
        logic                      valid;
        t_mul_op                   op;
        logic signed [OPND_W-1:0]  a;
        logic signed [OPND_W-1:0]  b;
        logic signed [SCORE_W-1:0] offset;
    } t_mul_cmd;

    // Saturate a wide signed value to the score range.
    function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-SCORE_W){1'b0}}, SCORE_MAX};
        lo = {{(PROD_W-SCORE_W){1'b1}}, SCORE_MIN};
        if (v > hi) begin
            return SCORE_MAX;
        end else if (v < lo) begin
            return SCORE_MIN;
        end else begin
            return v[SCORE_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/hbpt_in_if.sv]
// Request channel interface: request type, score and query count.
`timescale 1ns / 1ps
`default_nettype none
interface hbpt_in_if import hbpt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   query_count;

    modport source (output valid, output req_type, output score, output query_count,
                    input ready);
    modport sink (input valid, input req_type, input score, input query_count,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/hbpt_out_if.sv]
// Result channel interface: threshold, prune flag and stored count.
`timescale 1ns / 1ps
`default_nettype none
interface hbpt_out_if import hbpt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] threshold;
    logic               want_prune;
    logic [CNT_W-1:0]   stored_count;

    modport source (output valid, output threshold, output want_prune, output stored_count,
                    input ready);
    modport sink (input valid, input threshold, input want_prune, input stored_count,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/hbpt_cfg_if.sv]
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface hbpt_cfg_if import hbpt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/hbpt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hbpt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/hbpt_mul_unit.sv]
// Shared two-stage multiply unit: bin index of a score offset, or a bin edge score.
`timescale 1ns / 1ps
`default_nettype none
module hbpt_mul_unit import hbpt_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_mul_cmd                    i_cmd,
    output logic                             o_valid,
    output logic [$clog2(NUM_BINS)-1:0]      o_bin,
    output logic signed [SCORE_W-1:0]        o_thr
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int Q_W   = PROD_W - 26;
    localparam logic [Q_W-1:0] MAX_BIN = Q_W'(NUM_BINS - 1);

    logic                      r_v1;
    t_mul_op                   r_op1;
    logic signed [SCORE_W-1:0] r_off1;
    logic signed [PROD_W-1:0]  r_prod;

    logic [Q_W-1:0]            q_round;
    logic signed [PROD_W-1:0]  thr_sum;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_cmd.valid;
            o_valid <= r_v1;
        end
    end

    // Stage one: the product.
    always_ff @(posedge i_clk) begin
        r_op1  <= i_cmd.op;
        r_off1 <= i_cmd.offset;
        r_prod <= $signed(i_cmd.a) * $signed(i_cmd.b);
    end

    // Round the Q.26 product to a bin, or add the origin to the edge offset.
    assign q_round = r_prod[PROD_W-1:26] + Q_W'(r_prod[25]);
    assign thr_sum = r_prod + $signed({{(PROD_W-SCORE_W){r_off1[SCORE_W-1]}}, r_off1});

    // Stage two: saturate and hold the result.
    always_ff @(posedge i_clk) begin
        unique case (r_op1)
            MUL_BIN: begin
                if (q_round > MAX_BIN) begin
                    o_bin <= MAX_BIN[BIN_W-1:0];
                end else begin
                    o_bin <= q_round[BIN_W-1:0];
                end
            end
            MUL_THR: begin
                o_thr <= sat_score(thr_sum);
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/hbpt_seq.sv]
// Request sequencer: decodes requests, drives the multiply unit and the bin memory.
`timescale 1ns / 1ps
`default_nettype none
module hbpt_seq import hbpt_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    hbpt_in_if.sink                          i_req,
    hbpt_out_if.source                       o_res,
    input  wire t_cfg                        i_cfg,
    output t_mul_cmd                         o_mul,
    input  wire logic                        i_mul_valid,
    input  wire logic [$clog2(NUM_BINS)-1:0] i_mul_bin,
    input  wire logic signed [SCORE_W-1:0]   i_mul_thr,
    output logic                             o_mem_we,
    output logic [$clog2(NUM_BINS)-1:0]      o_mem_waddr,
    output logic [CNT_W-1:0]                 o_mem_wdata,
    output logic [$clog2(NUM_BINS)-1:0]      o_mem_raddr,
    input  wire logic [CNT_W-1:0]            i_mem_rdata
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    t_state r_state;
    t_state n_state;

    logic [REQ_W-1:0]          r_req;
    logic signed [SCORE_W-1:0] r_score;
    logic [CNT_W-1:0]          r_want;
    logic signed [SCORE_W-1:0] r_min;
    logic signed [SCORE_W-1:0] r_max;
    logic [CNT_W-1:0]          r_total;
    logic [BIN_W-1:0]          r_bin;
    logic [BIN_W-1:0]          r_sbin;
    logic [CNT_W:0]            r_acc;
    logic signed [SCORE_W-1:0] r_thr;
    logic [BIN_W-1:0]          r_clr_addr;
    logic                      r_clr_resp;
    logic                      r_out_valid;
    logic [SCORE_W-1:0]        r_out_thr;
    logic                      r_out_want;
    logic [CNT_W-1:0]          r_out_cnt;

    logic                      in_fire;
    logic                      out_free;
    logic                      in_range;
    logic signed [SCORE_W:0]   beam_s;
    logic signed [SCORE_W:0]   spread;
    logic signed [SCORE_W:0]   beam_diff;
    logic                      beam_on;
    logic                      beam_cut;
    logic                      no_walk;
    logic [CNT_W:0]            acc_n;
    logic                      walk_done;
    logic                      want_prune;
    logic [SCORE_W-1:0]        d_score;
    logic [SCORE_W-1:0]        d_min;
    logic [SCORE_W-1:0]        d_max;
    logic signed [BIN_W:0]     edge_k;
    logic                      clr_last;

    // Handshakes.
    assign in_fire  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;

    // Range, beam and walk decisions on the held state.
    assign in_range  = ($signed(r_score) >= $signed(i_cfg.score_floor)) &&
                       ($signed(r_score) <= $signed(i_cfg.score_ceiling));
    assign beam_s    = $signed({2'b00, i_cfg.beam_width});
    assign spread    = $signed({r_max[SCORE_W-1], r_max}) - $signed({r_min[SCORE_W-1], r_min});
    assign beam_diff = $signed({r_max[SCORE_W-1], r_max}) - beam_s;
    assign beam_on   = i_cfg.beam_width != '0;
    assign beam_cut  = beam_on && (spread > beam_s);
    assign no_walk   = (r_total <= r_want) ||
                       ($signed(r_min) < $signed(i_cfg.score_floor)) ||
                       ($signed(r_max) > $signed(i_cfg.score_ceiling));
    assign want_prune = (r_total > i_cfg.count_limit) || (beam_on && (spread <= beam_s));

    // Offsets from the histogram origin; they stay below 2^32 where used.
    assign d_score = r_score - i_cfg.score_floor;
    assign d_min   = r_min - i_cfg.score_floor;
    assign d_max   = r_max - i_cfg.score_floor;

    // Walk accumulation; the threshold is the lower edge of the bin below.
    assign acc_n     = r_acc + {1'b0, i_mem_rdata};
    assign walk_done = (acc_n >= {1'b0, r_want}) || (r_bin == r_sbin);
    assign edge_k    = $signed({1'b0, r_bin}) - $signed((BIN_W+1)'(1));
    assign clr_last  = r_clr_addr == LAST_BIN;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_resp ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (r_req == REQ_ADD) begin
                    n_state = in_range ? ST_ADD_BIN : ST_RESP;
                end else if (r_req == REQ_QUERY) begin
                    n_state = (beam_cut || no_walk) ? ST_RESP : ST_Q_SMIN;
                end else if (r_req == REQ_CLEAR) begin
                    n_state = ST_CLEAR;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_ADD_BIN: begin
                if (i_mul_valid) begin
                    n_state = ST_ADD_RD;
                end
            end
            ST_ADD_RD: begin
                n_state = ST_RESP;
            end
            ST_Q_SMIN: begin
                if (i_mul_valid) begin
                    n_state = ST_Q_EMAX;
                end
            end
            ST_Q_EMAX: begin
                if (i_mul_valid) begin
                    n_state = ST_Q_WALK;
                end
            end
            ST_Q_WALK: begin
                if (walk_done) begin
                    n_state = ST_Q_THR;
                end
            end
            ST_Q_THR: begin
                if (i_mul_valid) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs: request ready, multiply commands and memory ports.
    always_comb begin
        i_req.ready  = 1'b0;
        o_mul        = '0;
        o_mul.op     = MUL_BIN;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_bin;
        o_mem_wdata  = '0;
        o_mem_raddr  = r_bin;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_DECODE: begin
                if (r_req == REQ_ADD && in_range) begin
                    o_mul.valid = 1'b1;
                    o_mul.a     = $signed({1'b0, d_score});
                    o_mul.b     = $signed({1'b0, i_cfg.bin_scale});
                end else if (r_req == REQ_QUERY && !beam_cut && !no_walk) begin
                    o_mul.valid = 1'b1;
                    o_mul.a     = $signed({1'b0, d_min});
                    o_mul.b     = $signed({1'b0, i_cfg.bin_scale});
                end
            end
            ST_ADD_BIN: begin
                o_mem_raddr = i_mul_bin;
            end
            ST_ADD_RD: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = (i_mem_rdata == CNT_MAX) ? i_mem_rdata : i_mem_rdata + 1'b1;
            end
            ST_Q_SMIN: begin
                if (i_mul_valid) begin
                    o_mul.valid = 1'b1;
                    o_mul.a     = $signed({1'b0, d_max});
                    o_mul.b     = $signed({1'b0, i_cfg.bin_scale});
                end
            end
            ST_Q_EMAX: begin
                o_mem_raddr = i_mul_bin;
            end
            ST_Q_WALK: begin
                o_mem_raddr = r_bin - 1'b1;
                if (walk_done) begin
                    o_mul.valid  = 1'b1;
                    o_mul.op     = MUL_THR;
                    o_mul.a      = $signed({{(OPND_W-BIN_W-1){edge_k[BIN_W]}}, edge_k});
                    o_mul.b      = $signed({2'b00, i_cfg.bin_step});
                    o_mul.offset = i_cfg.score_floor;
                end
            end
            ST_Q_THR: begin
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Request state, histogram summary and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= SCORE_MAX;
            r_max      <= SCORE_MIN;
            r_total    <= '0;
            r_clr_addr <= '0;
            r_clr_resp <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_req   <= i_req.req_type;
                        r_score <= i_req.score;
                        r_want  <= i_req.query_count;
                        r_thr   <= '0;
                    end
                end
                ST_DECODE: begin
                    if (r_req == REQ_ADD && in_range) begin
                        if ($signed(r_score) < $signed(r_min)) begin
                            r_min <= r_score;
                        end
                        if ($signed(r_score) > $signed(r_max)) begin
                            r_max <= r_score;
                        end
                        if (r_total != CNT_MAX) begin
                            r_total <= r_total + 1'b1;
                        end
                    end else if (r_req == REQ_QUERY) begin
                        if (beam_cut) begin
                            r_thr <= sat_score($signed({{(PROD_W-SCORE_W-1){beam_diff[SCORE_W]}},
                                                        beam_diff}));
                        end else if (no_walk) begin
                            r_thr <= i_cfg.score_floor;
                        end
                    end else if (r_req == REQ_CLEAR) begin
                        r_min      <= SCORE_MAX;
                        r_max      <= SCORE_MIN;
                        r_total    <= '0;
                        r_clr_addr <= '0;
                        r_clr_resp <= 1'b1;
                    end
                end
                ST_ADD_BIN: begin
                    if (i_mul_valid) begin
                        r_bin <= i_mul_bin;
                    end
                end
                ST_Q_SMIN: begin
                    if (i_mul_valid) begin
                        r_sbin <= i_mul_bin;
                    end
                end
                ST_Q_EMAX: begin
                    if (i_mul_valid) begin
                        r_bin <= i_mul_bin;
                        r_acc <= '0;
                    end
                end
                ST_Q_WALK: begin
                    r_acc <= acc_n;
                    if (!walk_done) begin
                        r_bin <= r_bin - 1'b1;
                    end
                end
                ST_Q_THR: begin
                    if (i_mul_valid) begin
                        r_thr <= i_mul_thr;
                    end
                end
                ST_CLEAR: begin
                    if (clr_last) begin
                        r_clr_addr <= '0;
                        r_clr_resp <= 1'b0;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: holds a result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && out_free) begin
            r_out_thr  <= r_thr;
            r_out_want <= want_prune;
            r_out_cnt  <= r_total;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.threshold    = r_out_thr;
    assign o_res.want_prune   = r_out_want;
    assign o_res.stored_count = r_out_cnt;

    // A multiply result only arrives while the sequencer waits for one.
    a_mul_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_valid |-> (r_state == ST_ADD_BIN || r_state == ST_Q_SMIN ||
                         r_state == ST_Q_EMAX || r_state == ST_Q_THR))
        else $error("multiply result arrived in an unexpected state");

    // The walk never passes below the bin of the smallest score.
    a_walk_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_WALK) |-> (r_bin >= r_sbin))
        else $error("histogram walk went below the minimum bin");

    // Before each walk step the running sum is still short of the query count.
    a_walk_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_WALK) |-> (r_acc < {1'b0, r_want} || r_acc == '0))
        else $error("walk continued after reaching the query count");

    // A walk only starts with more stored items than requested.
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_WALK) |-> (r_total > r_want))
        else $error("walk started without enough stored items");

    // The summary is empty while the bins are being cleared.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (r_total == '0 && r_min == SCORE_MAX && r_max == SCORE_MIN))
        else $error("histogram summary not empty during clearing");

endmodule
`default_nettype wire

[hw/rtl/histogram_beam_prune_threshold_unit.sv]
// Histogram beam prune threshold unit: register bank, sequencer, multiply unit, bin RAM.
// Add: request beat to result beat through a bin multiply, a RAM read and a RAM write.
// Query: a beam or early exit answers from decode, else two bin multiplies, a bin walk and an edge multiply.
// Clear: a RAM clearing pass over all NUM_BINS bins; one request at a time.
// Reset is synchronous, active low; it starts a clearing pass of the bin RAM
// during which no request is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module histogram_beam_prune_threshold_unit import hbpt_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbpt_in_if.sink    i_req,
    hbpt_out_if.source o_res,
    hbpt_cfg_if.sink   i_cfg
);

    localparam int BIN_W = $clog2(NUM_BINS);

    t_cfg                      r_cfg;
    t_mul_cmd                  mul_cmd;
    logic                      mul_valid;
    logic [BIN_W-1:0]          mul_bin;
    logic signed [SCORE_W-1:0] mul_thr;
    logic                      mem_we;
    logic [BIN_W-1:0]          mem_waddr;
    logic [CNT_W-1:0]          mem_wdata;
    logic [BIN_W-1:0]          mem_raddr;
    logic [CNT_W-1:0]          mem_rdata;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Configuration register bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_floor   <= FLOOR_RST;
            r_cfg.score_ceiling <= CEILING_RST;
            r_cfg.bin_step      <= BIN_W_RST;
            r_cfg.bin_scale     <= SCALE_RST;
            r_cfg.count_limit   <= LIMIT_RST;
            r_cfg.beam_width    <= BEAM_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SCORE_FLOOR:   r_cfg.score_floor   <= i_cfg.data;
                CFG_SCORE_CEILING: r_cfg.score_ceiling <= i_cfg.data;
                CFG_BIN_WIDTH:     r_cfg.bin_step      <= i_cfg.data[BW_W-1:0];
                CFG_BIN_SCALE:     r_cfg.bin_scale     <= i_cfg.data[SCALE_W-1:0];
                CFG_COUNT_LIMIT:   r_cfg.count_limit   <= i_cfg.data[CNT_W-1:0];
                CFG_BEAM_WIDTH:    r_cfg.beam_width    <= i_cfg.data[BW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request sequencer.
    hbpt_seq #(
        .NUM_BINS (NUM_BINS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_cfg       (r_cfg),
        .o_mul       (mul_cmd),
        .i_mul_valid (mul_valid),
        .i_mul_bin   (mul_bin),
        .i_mul_thr   (mul_thr),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Shared multiply unit.
    hbpt_mul_unit #(
        .NUM_BINS (NUM_BINS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mul_cmd),
        .o_valid (mul_valid),
        .o_bin   (mul_bin),
        .o_thr   (mul_thr)
    );

    // Bin count memory.
    hbpt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire
